### sv/page_bitmap_first_fit_allocator_top_defines.svh
// Assertion macros for the page bitmap allocator.
`ifndef PAGE_BITMAP_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_BITMAP_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define PBFFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PBFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pbffa_pkg.sv
`timescale 1ns / 1ps

package pbffa_pkg;

    localparam int MAX_DATA_PAGES = 256;

    localparam int ACT_W      = 3;
    localparam int SIZE_W     = 24;
    localparam int PAGE_W     = 8;
    localparam int CNT_OUT_W  = 9;
    localparam int PSL_W      = 5;
    localparam int DP_W       = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int PCNT_W     = 17;

    localparam logic [ACT_W-1:0] ACT_ALLOC     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPLACE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MARK_USED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MARK_FREE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_PAGES     = 1'b1;

    localparam logic [PSL_W-1:0] PSL_RESET = 5'd12;
    localparam logic [PSL_W-1:0] PSL_MIN   = 5'd8;
    localparam logic [PSL_W-1:0] PSL_MAX   = 5'd16;
    localparam logic [DP_W-1:0]  DP_RESET  = 9'd256;

    // Rounds a byte size up to whole pages; an empty size takes one page.
    function automatic logic [PCNT_W-1:0] pages_for(input logic [SIZE_W-1:0] size,
                                                    input logic [PSL_W-1:0] sh);
        logic [SIZE_W:0] ps_m1;
        logic [SIZE_W:0] sum;
        logic [SIZE_W:0] shifted;
        ps_m1   = ((SIZE_W+1)'(1) << sh) - (SIZE_W+1)'(1);
        sum     = {1'b0, size} + ps_m1;
        shifted = sum >> sh;
        if (size == '0) begin
            return PCNT_W'(1);
        end
        return shifted[PCNT_W-1:0];
    endfunction

    // Saturates a page count at the data page count.
    function automatic logic [CNT_OUT_W-1:0] sat_pages(input logic [PCNT_W-1:0] cnt,
                                                       input logic [DP_W-1:0] d);
        if (cnt > PCNT_W'(d)) begin
            return CNT_OUT_W'(d);
        end
        return cnt[CNT_OUT_W-1:0];
    endfunction

endpackage

### sv/page_bitmap_first_fit_allocator_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_action, i_size_bytes, i_old_start_page,
//                                                 i_old_size_bytes
// output    out        o_out_valid / i_out_stall  o_found, o_start_page, o_page_count
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item at a time in a one-bit memory with one write and one registered read per cycle.
// Allocate: a count step, a scan, marking and a response. The scan ends on a fit, after all data
// pages are read on no fit, and before any page is checked when the request exceeds the pages.
// Replace adds a count step for the old size and frees the old run first; on no fit it restores it.
// Mark used or free: a count step, the marking and a response. Clear all sweeps every memory page.
// After reset a clearing sweep over every memory page runs; a stalled result holds the response.
module page_bitmap_first_fit_allocator_top #(
    parameter int MAX_DATA_PAGES = pbffa_pkg::MAX_DATA_PAGES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbffa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbffa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [pbffa_pkg::ACT_W-1:0]      i_action,
    input  logic [pbffa_pkg::SIZE_W-1:0]     i_size_bytes,
    input  logic [pbffa_pkg::PAGE_W-1:0]     i_old_start_page,
    input  logic [pbffa_pkg::SIZE_W-1:0]     i_old_size_bytes,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [pbffa_pkg::PAGE_W-1:0]     o_start_page,
    output logic [pbffa_pkg::CNT_OUT_W-1:0]  o_page_count
);

`include "page_bitmap_first_fit_allocator_top_defines.svh"

    localparam int PW = (MAX_DATA_PAGES > 1) ? $clog2(MAX_DATA_PAGES) : 1;
    localparam int CW = ((PW > pbffa_pkg::DP_W) ? PW : pbffa_pkg::DP_W) + 1;
    localparam logic [pbffa_pkg::DP_W-1:0] MAXD =
        pbffa_pkg::DP_W'((MAX_DATA_PAGES < 511) ? MAX_DATA_PAGES : 511);
    localparam logic [CW-1:0] LAST_PAGE = CW'(MAX_DATA_PAGES - 1);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_CNT_NEW = 8'b0000_0100,
        S_CNT_OLD = 8'b0000_1000,
        S_MARK    = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_RESP    = 8'b0100_0000
    } t_state;

    t_state r_state, n_state;

    logic [pbffa_pkg::PSL_W-1:0] r_psl;
    logic [pbffa_pkg::DP_W-1:0]  r_dp;
    logic [pbffa_pkg::PSL_W-1:0] w_log2;
    logic [pbffa_pkg::DP_W-1:0]  w_d;

    logic [pbffa_pkg::ACT_W-1:0]  r_act, n_act;
    logic [pbffa_pkg::SIZE_W-1:0] r_size, n_size;
    logic [pbffa_pkg::PAGE_W-1:0] r_ostart, n_ostart;
    logic [pbffa_pkg::SIZE_W-1:0] r_osize, n_osize;
    logic [pbffa_pkg::PCNT_W-1:0] r_cnt, n_cnt;
    logic [pbffa_pkg::PCNT_W-1:0] r_ocnt, n_ocnt;

    logic [CW-1:0] r_mk_start, n_mk_start;
    logic [CW-1:0] r_mk_lim, n_mk_lim;
    logic [CW-1:0] r_mk_i, n_mk_i;
    logic          r_mk_val, n_mk_val;
    logic          r_mk_scan, n_mk_scan;
    logic [CW-1:0] w_mk_p;

    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_chk_page, n_chk_page;
    logic          r_chk_vld, n_chk_vld;
    logic          r_rdata;
    logic [CW-1:0] w_run_n;
    logic [CW-1:0] w_fit_start;

    logic [CW-1:0] r_clr, n_clr;
    logic          r_clr_resp, n_clr_resp;

    logic                            r_res_found, n_res_found;
    logic [pbffa_pkg::PAGE_W-1:0]    r_res_start, n_res_start;
    logic [pbffa_pkg::CNT_OUT_W-1:0] r_res_count, n_res_count;

    logic                            r_out_vld, n_out_vld;
    logic                            r_out_found, n_out_found;
    logic [pbffa_pkg::PAGE_W-1:0]    r_out_start, n_out_start;
    logic [pbffa_pkg::CNT_OUT_W-1:0] r_out_count, n_out_count;

    logic [pbffa_pkg::SIZE_W-1:0]    w_cnt_src;
    logic [pbffa_pkg::PCNT_W-1:0]    w_pcnt;
    logic [pbffa_pkg::CNT_OUT_W-1:0] w_pcnt_sat;
    logic [pbffa_pkg::CNT_OUT_W-1:0] w_cnt_sat;
    logic [pbffa_pkg::CNT_OUT_W-1:0] w_ocnt_sat;

    logic          r_mem [MAX_DATA_PAGES];
    logic          w_we;
    logic [PW-1:0] w_addr;
    logic          w_wdata;

    always_comb begin
        if (r_psl < pbffa_pkg::PSL_MIN) begin
            w_log2 = pbffa_pkg::PSL_MIN;
        end else if (r_psl > pbffa_pkg::PSL_MAX) begin
            w_log2 = pbffa_pkg::PSL_MAX;
        end else begin
            w_log2 = r_psl;
        end
        if (r_dp == '0) begin
            w_d = pbffa_pkg::DP_W'(1);
        end else if (r_dp > MAXD) begin
            w_d = MAXD;
        end else begin
            w_d = r_dp;
        end
    end

    // The page count unit is shared by the new and the old size.
    assign w_cnt_src   = (r_state == S_CNT_NEW) ? r_size : r_osize;
    assign w_pcnt      = pbffa_pkg::pages_for(w_cnt_src, w_log2);
    assign w_pcnt_sat  = pbffa_pkg::sat_pages(w_pcnt, w_d);
    assign w_cnt_sat   = pbffa_pkg::sat_pages(r_cnt, w_d);
    assign w_ocnt_sat  = pbffa_pkg::sat_pages(r_ocnt, w_d);
    assign w_mk_p      = r_mk_start + r_mk_i;
    assign w_run_n     = r_rdata ? '0 : (r_run + CW'(1));
    assign w_fit_start = r_chk_page - CW'(r_cnt) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_size      = r_size;
        n_ostart    = r_ostart;
        n_osize     = r_osize;
        n_cnt       = r_cnt;
        n_ocnt      = r_ocnt;
        n_mk_start  = r_mk_start;
        n_mk_lim    = r_mk_lim;
        n_mk_i      = r_mk_i;
        n_mk_val    = r_mk_val;
        n_mk_scan   = r_mk_scan;
        n_ptr       = '0;
        n_run       = '0;
        n_chk_vld   = 1'b0;
        n_chk_page  = r_chk_page;
        n_clr       = r_clr;
        n_clr_resp  = r_clr_resp;
        n_res_found = r_res_found;
        n_res_start = r_res_start;
        n_res_count = r_res_count;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out_found = r_out_found;
        n_out_start = r_out_start;
        n_out_count = r_out_count;
        w_we        = 1'b0;
        w_addr      = w_mk_p[PW-1:0];
        w_wdata     = r_mk_val;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr[PW-1:0];
                w_wdata = 1'b0;
                n_clr   = r_clr + CW'(1);
                if (r_clr == LAST_PAGE) begin
                    n_clr = '0;
                    if (r_clr_resp) begin
                        n_res_found = 1'b1;
                        n_res_start = '0;
                        n_res_count = '0;
                        n_state     = S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                n_clr_resp = 1'b0;
                if (i_in_valid) begin
                    n_act    = i_action;
                    n_size   = i_size_bytes;
                    n_ostart = i_old_start_page;
                    n_osize  = i_old_size_bytes;
                    case (i_action)
                        pbffa_pkg::ACT_ALLOC,
                        pbffa_pkg::ACT_REPLACE: begin
                            n_state = S_CNT_NEW;
                        end
                        pbffa_pkg::ACT_MARK_USED,
                        pbffa_pkg::ACT_MARK_FREE: begin
                            n_state = S_CNT_OLD;
                        end
                        pbffa_pkg::ACT_CLEAR_ALL: begin
                            n_clr_resp = 1'b1;
                            n_clr      = '0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_res_found = 1'b0;
                            n_res_start = '0;
                            n_res_count = '0;
                            n_state     = S_RESP;
                        end
                    endcase
                end
            end
            S_CNT_NEW: begin
                n_cnt   = w_pcnt;
                n_state = (r_act == pbffa_pkg::ACT_REPLACE) ? S_CNT_OLD : S_SCAN;
            end
            S_CNT_OLD: begin
                n_ocnt      = w_pcnt;
                n_mk_start  = CW'(r_ostart);
                n_mk_lim    = CW'(w_pcnt_sat);
                n_mk_i      = '0;
                n_mk_val    = (r_act == pbffa_pkg::ACT_MARK_USED);
                n_mk_scan   = (r_act == pbffa_pkg::ACT_REPLACE);
                n_res_found = 1'b1;
                n_res_start = r_ostart;
                n_res_count = w_pcnt_sat;
                n_state     = S_MARK;
            end
            S_MARK: begin
                if ((r_mk_i < r_mk_lim) && (w_mk_p < CW'(w_d))) begin
                    w_we   = 1'b1;
                    n_mk_i = r_mk_i + CW'(1);
                end else begin
                    n_state = r_mk_scan ? S_SCAN : S_RESP;
                end
            end
            S_SCAN: begin
                n_run = r_chk_vld ? w_run_n : r_run;
                if (r_ptr < CW'(w_d)) begin
                    n_chk_vld  = 1'b1;
                    n_chk_page = r_ptr;
                    n_ptr      = r_ptr + CW'(1);
                end else begin
                    n_ptr = r_ptr;
                end
                if ((r_cnt <= pbffa_pkg::PCNT_W'(w_d)) && r_chk_vld
                        && (w_run_n == CW'(r_cnt))) begin
                    n_mk_start  = w_fit_start;
                    n_mk_lim    = CW'(r_cnt);
                    n_mk_i      = '0;
                    n_mk_val    = 1'b1;
                    n_mk_scan   = 1'b0;
                    n_res_found = 1'b1;
                    n_res_start = w_fit_start[pbffa_pkg::PAGE_W-1:0];
                    n_res_count = w_cnt_sat;
                    n_state     = S_MARK;
                end else if ((r_cnt > pbffa_pkg::PCNT_W'(w_d))
                        || (!r_chk_vld && !(r_ptr < CW'(w_d)))) begin
                    n_res_found = 1'b0;
                    n_res_start = '0;
                    n_res_count = w_cnt_sat;
                    if (r_act == pbffa_pkg::ACT_REPLACE) begin
                        n_mk_start = CW'(r_ostart);
                        n_mk_lim   = CW'(w_ocnt_sat);
                        n_mk_i     = '0;
                        n_mk_val   = 1'b1;
                        n_mk_scan  = 1'b0;
                        n_state    = S_MARK;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_res_found;
                    n_out_start = r_res_start;
                    n_out_count = r_res_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_ptr[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psl <= pbffa_pkg::PSL_RESET;
            r_dp  <= pbffa_pkg::DP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbffa_pkg::CFG_PAGE_SIZE_LOG2: begin
                    r_psl <= i_cfg_data[pbffa_pkg::PSL_W-1:0];
                end
                pbffa_pkg::CFG_DATA_PAGES: begin
                    r_dp <= i_cfg_data[pbffa_pkg::DP_W-1:0];
                end
                default: begin
                    r_psl <= r_psl;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_clr_resp <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_ptr      <= '0;
            r_run      <= '0;
            r_mk_i     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_clr_resp <= n_clr_resp;
            r_chk_vld  <= n_chk_vld;
            r_ptr      <= n_ptr;
            r_run      <= n_run;
            r_mk_i     <= n_mk_i;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_size      <= n_size;
        r_ostart    <= n_ostart;
        r_osize     <= n_osize;
        r_cnt       <= n_cnt;
        r_ocnt      <= n_ocnt;
        r_mk_start  <= n_mk_start;
        r_mk_lim    <= n_mk_lim;
        r_mk_val    <= n_mk_val;
        r_mk_scan   <= n_mk_scan;
        r_chk_page  <= n_chk_page;
        r_res_found <= n_res_found;
        r_res_start <= n_res_start;
        r_res_count <= n_res_count;
        r_out_found <= n_out_found;
        r_out_start <= n_out_start;
        r_out_count <= n_out_count;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_found      = r_out_found;
    assign o_start_page = r_out_start;
    assign o_page_count = r_out_count;

    `PBFFA_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && !o_in_stall, r_state != S_IDLE, "item not started")
    `PBFFA_ASSERT_NOW(a_result_from_resp, $rose(r_out_vld), $past(r_state == S_RESP), "stray result")
    `PBFFA_ASSERT_NOW(a_mark_within_pages, r_state == S_MARK, r_mk_lim <= CW'(w_d), "run too long")

endmodule

### tb/sv/tb_page_bitmap_first_fit_allocator_top.sv
`timescale 1ns / 1ps

module tb_page_bitmap_first_fit_allocator_top;

    localparam int MAX_DATA_PAGES = pbffa_pkg::MAX_DATA_PAGES;
    localparam int ACT_W          = pbffa_pkg::ACT_W;
    localparam int SIZE_W         = pbffa_pkg::SIZE_W;
    localparam int PAGE_W         = pbffa_pkg::PAGE_W;
    localparam int CNT_OUT_W      = pbffa_pkg::CNT_OUT_W;
    localparam int PSL_W          = pbffa_pkg::PSL_W;
    localparam int DP_W           = pbffa_pkg::DP_W;
    localparam int CFG_IDX_W      = pbffa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = pbffa_pkg::CFG_DATA_W;

    localparam logic [ACT_W-1:0] ACT_ALLOC     = pbffa_pkg::ACT_ALLOC;
    localparam logic [ACT_W-1:0] ACT_REPLACE   = pbffa_pkg::ACT_REPLACE;
    localparam logic [ACT_W-1:0] ACT_MARK_USED = pbffa_pkg::ACT_MARK_USED;
    localparam logic [ACT_W-1:0] ACT_MARK_FREE = pbffa_pkg::ACT_MARK_FREE;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = pbffa_pkg::ACT_CLEAR_ALL;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = pbffa_pkg::CFG_PAGE_SIZE_LOG2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_PAGES     = pbffa_pkg::CFG_DATA_PAGES;

    localparam logic [PSL_W-1:0] PSL_RESET = pbffa_pkg::PSL_RESET;
    localparam logic [PSL_W-1:0] PSL_MIN   = pbffa_pkg::PSL_MIN;
    localparam logic [PSL_W-1:0] PSL_MAX   = pbffa_pkg::PSL_MAX;
    localparam logic [DP_W-1:0]  DP_RESET  = pbffa_pkg::DP_RESET;

    localparam int HALF_PERIOD    = 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 500;
    localparam int END_DRAIN      = 300;

    localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic                 found;
        logic [PAGE_W-1:0]    start_page;
        logic [CNT_OUT_W-1:0] page_count;
    } t_alloc_result;

    typedef struct {
        int                start;
        logic [SIZE_W-1:0] size;
    } t_live_run;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [ACT_W-1:0]      i_action         = '0;
    logic [SIZE_W-1:0]     i_size_bytes     = '0;
    logic [PAGE_W-1:0]     i_old_start_page = '0;
    logic [SIZE_W-1:0]     i_old_size_bytes = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic                  o_found;
    logic [PAGE_W-1:0]     o_start_page;
    logic [CNT_OUT_W-1:0]  o_page_count;

    logic             bitmap_used [MAX_DATA_PAGES] = '{default: 1'b0};
    logic [PSL_W-1:0] cfg_psl = PSL_RESET;
    logic [DP_W-1:0]  cfg_dp  = DP_RESET;

    t_alloc_result pending_results [$];
    t_live_run     live_runs [$];

    int  error_count   = 0;
    int  quiet_cycles  = 0;
    int  burst_left    = 0;
    bit  gaps_on       = 1'b1;
    bit  stall_on      = 1'b1;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    int  seg_left      = 0;
    bit  stall_phase   = 1'b0;

    page_bitmap_first_fit_allocator_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_size_bytes     (i_size_bytes),
        .i_old_start_page (i_old_start_page),
        .i_old_size_bytes (i_old_size_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_start_page     (o_start_page),
        .o_page_count     (o_page_count)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic int eff_shift();
        if (cfg_psl < PSL_MIN) return int'(PSL_MIN);
        if (cfg_psl > PSL_MAX) return int'(PSL_MAX);
        return int'(cfg_psl);
    endfunction

    function automatic int usable_pages();
        if (int'(cfg_dp) < 1) return 1;
        if (int'(cfg_dp) > MAX_DATA_PAGES) return MAX_DATA_PAGES;
        return int'(cfg_dp);
    endfunction

    function automatic int page_count_of(input logic [SIZE_W-1:0] size);
        int sh;
        sh = eff_shift();
        if (size == '0) return 1;
        return int'((longint'(size) + (longint'(1) << sh) - 1) >> sh);
    endfunction

    function automatic void mark_pages(input int start, input int cnt, input logic used);
        int d;
        d = usable_pages();
        if (cnt > d) cnt = d;
        for (int i = 0; i < cnt; i++) begin
            if (start + i < d) bitmap_used[start + i] = used;
        end
    endfunction

    function automatic bit find_free_run(input int cnt, output int start);
        int d;
        bit ok;
        d = usable_pages();
        start = 0;
        if (cnt > d) return 1'b0;
        for (int s = 0; s + cnt <= d; s++) begin
            ok = 1'b1;
            for (int i = 0; i < cnt; i++) begin
                if (bitmap_used[s + i]) begin
                    ok = 1'b0;
                    break;
                end
            end
            if (ok) begin
                start = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_alloc_result bitmap_apply(input logic [ACT_W-1:0] act,
                                                   input logic [SIZE_W-1:0] sz,
                                                   input logic [PAGE_W-1:0] ost,
                                                   input logic [SIZE_W-1:0] osz);
        t_alloc_result r;
        int d;
        int cnt;
        int ocnt;
        int s;
        r = '0;
        d = usable_pages();
        case (act)
            ACT_ALLOC, ACT_REPLACE: begin
                cnt  = page_count_of(sz);
                ocnt = page_count_of(osz);
                if (act == ACT_REPLACE) mark_pages(int'(ost), ocnt, 1'b0);
                if (find_free_run(cnt, s)) begin
                    mark_pages(s, cnt, 1'b1);
                    r.found      = 1'b1;
                    r.start_page = PAGE_W'(s);
                end else if (act == ACT_REPLACE) begin
                    mark_pages(int'(ost), ocnt, 1'b1);
                end
                r.page_count = CNT_OUT_W'((cnt > d) ? d : cnt);
            end
            ACT_MARK_USED, ACT_MARK_FREE: begin
                ocnt = page_count_of(osz);
                mark_pages(int'(ost), ocnt, act == ACT_MARK_USED);
                r.found      = 1'b1;
                r.start_page = ost;
                r.page_count = CNT_OUT_W'((ocnt > d) ? d : ocnt);
            end
            ACT_CLEAR_ALL: begin
                foreach (bitmap_used[i]) bitmap_used[i] = 1'b0;
                r.found = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Mostly sizes of a few pages, with some up to and past the whole data area.
    function automatic logic [SIZE_W-1:0] random_size(input int d);
        int pick;
        int k;
        int sh;
        longint lo;
        longint hi;
        pick = $urandom_range(0, 99);
        if (pick < 8) return SIZE_W'($urandom);
        if (pick < 13) return '0;
        if (pick < 70) k = $urandom_range(1, (d < 8) ? d : 8);
        else if (pick < 92) k = $urandom_range(1, d);
        else k = $urandom_range(d + 1, d + 4);
        sh = eff_shift();
        hi = longint'(k) << sh;
        lo = hi - (longint'(1) << sh) + 1;
        if (hi > (longint'(1) << SIZE_W) - 1) hi = (longint'(1) << SIZE_W) - 1;
        if (lo > hi) lo = hi;
        return SIZE_W'(lo + $urandom_range(0, int'(hi - lo)));
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [SIZE_W-1:0] sz,
                             input logic [PAGE_W-1:0] ost, input logic [SIZE_W-1:0] osz,
                             output t_alloc_result res);
        int gap;
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_size_bytes     <= sz;
        i_old_start_page <= ost;
        i_old_size_bytes <= osz;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = bitmap_apply(act, sz, ost, osz);
        pending_results.push_back(res);
        if (burst_left > 0) burst_left--;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(1, 20);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] psl_data,
                              input logic [CFG_DATA_W-1:0] dp_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PAGE_SIZE_LOG2;
        i_cfg_data <= psl_data;
        @(posedge i_clk);
        cfg_psl = psl_data[PSL_W-1:0];
        i_cfg_idx  <= CFG_DATA_PAGES;
        i_cfg_data <= dp_data;
        @(posedge i_clk);
        cfg_dp = dp_data[DP_W-1:0];
        i_cfg_we <= 1'b0;
    endtask

    // Replace and mark free mostly target runs that are known to be allocated.
    task automatic run_random(input int n_items);
        int d;
        int pick;
        int idx;
        bit from_live;
        t_live_run old_run;
        logic [ACT_W-1:0] act;
        logic [SIZE_W-1:0] sz;
        logic [SIZE_W-1:0] osz;
        logic [PAGE_W-1:0] ost;
        t_alloc_result res;
        repeat (n_items) begin
            d = usable_pages();
            from_live = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 40) act = ACT_ALLOC;
            else if (pick < 60) act = ACT_REPLACE;
            else if (pick < 78) act = ACT_MARK_FREE;
            else if (pick < 90) act = ACT_MARK_USED;
            else if (pick < 94) act = ACT_CLEAR_ALL;
            else if (pick < 97) act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            else act = ACT_ALLOC;
            sz  = random_size(d);
            osz = random_size(d);
            if ($urandom_range(0, 4) == 0) ost = PAGE_W'($urandom);
            else ost = PAGE_W'($urandom_range(0, d - 1));
            if ((act == ACT_REPLACE || act == ACT_MARK_FREE) && live_runs.size() != 0
                    && $urandom_range(0, 3) != 0) begin
                idx = $urandom_range(0, live_runs.size() - 1);
                old_run = live_runs[idx];
                live_runs.delete(idx);
                from_live = 1'b1;
                ost = PAGE_W'(old_run.start);
                osz = old_run.size;
            end
            send_item(act, sz, ost, osz, res);
            if (act == ACT_CLEAR_ALL) begin
                live_runs.delete();
            end else if ((act == ACT_ALLOC || act == ACT_REPLACE) && res.found) begin
                live_runs.push_back('{int'(res.start_page), sz});
            end else if (act == ACT_REPLACE && from_live) begin
                live_runs.push_back(old_run);
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] psl_data,
                             input logic [CFG_DATA_W-1:0] dp_data,
                             input bit gaps, input bit stalls, input int n_items);
        set_config(psl_data, dp_data);
        live_runs.delete();
        gaps_on  = gaps;
        stall_on = stalls;
        run_random(n_items);
        wait_for_results();
    endtask

    task automatic test_directed_actions();
        t_alloc_result res;
        send_item(ACT_ALLOC, 24'd0, 8'd0, 24'd0, res);
        send_item(ACT_ALLOC, 24'd4096, 8'd0, 24'd0, res);
        send_item(ACT_ALLOC, 24'd4097, 8'd0, 24'd0, res);
        send_item(ACT_ALLOC, 24'hFFFFFF, 8'd0, 24'd0, res);
        send_item(ACT_MARK_FREE, 24'd0, 8'd1, 24'd0, res);
        send_item(ACT_ALLOC, 24'd8192, 8'd0, 24'd0, res);
        send_item(ACT_REPLACE, 24'd12288, 8'd4, 24'd8192, res);
        send_item(ACT_REPLACE, 24'(300 * 4096), 8'd0, 24'd1, res);
        send_item(ACT_MARK_USED, 24'd0, 8'd255, 24'hFFFFFF, res);
        for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++) begin
            send_item(ACT_W'(a), '1, '1, '1, res);
        end
        send_item(ACT_CLEAR_ALL, 24'd0, 8'd0, 24'd0, res);
        // The only fitting position is the very last one.
        send_item(ACT_MARK_USED, 24'd0, 8'd0, 24'd1, res);
        send_item(ACT_ALLOC, 24'(255 * 4096), 8'd0, 24'd0, res);
        send_item(ACT_ALLOC, 24'd0, 8'd0, 24'd0, res);
        send_item(ACT_CLEAR_ALL, '1, '1, '1, res);
        wait_for_results();
    endtask

    task automatic test_setting_extremes();
        t_alloc_result res;
        set_config(9'd0, 9'd0);
        send_item(ACT_ALLOC, 24'd256, 8'd0, 24'd0, res);
        send_item(ACT_ALLOC, 24'd0, 8'd0, 24'd0, res);
        send_item(ACT_REPLACE, 24'd257, 8'd0, 24'd256, res);
        send_item(ACT_MARK_FREE, 24'd0, 8'd255, 24'hFFFFFF, res);
        wait_for_results();
        set_config(9'h1FF, 9'h1FF);
        send_item(ACT_CLEAR_ALL, 24'd0, 8'd0, 24'd0, res);
        send_item(ACT_ALLOC, 24'hFFFFFF, 8'd0, 24'd0, res);
        send_item(ACT_MARK_FREE, 24'd0, 8'd128, 24'd65537, res);
        wait_for_results();
    endtask

    task automatic test_receiver_hold();
        t_alloc_result res;
        set_config(9'd12, 9'd32);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        hold_requests++;
        repeat (16) send_item(ACT_ALLOC, SIZE_W'($urandom_range(0, 3 * 4096)), 8'd0, 24'd0, res);
        wait_for_results();
    endtask

    task automatic test_random_settings();
        run_phase(9'd12, 9'd16, 1'b1, 1'b1, 150);
        run_phase(9'd8, 9'd8, 1'b1, 1'b0, 150);
        run_phase(9'd16, 9'd64, 1'b0, 1'b1, 150);
        run_phase(9'h1FF, 9'd300, 1'b1, 1'b1, 100);
        run_phase(9'd10, 9'd256, 1'b1, 1'b1, 150);
        run_phase(9'h1E0, 9'd0, 1'b1, 1'b1, 60);
        run_phase(9'd9, 9'd33, 1'b0, 1'b0, 150);
        run_phase(9'd13, 9'd100, 1'b1, 1'b1, 150);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (stall_on) begin
            if (seg_left == 0) begin
                stall_phase <= !stall_phase;
                i_out_stall <= !stall_phase;
                seg_left    <= stall_phase ? $urandom_range(0, 9) : $urandom_range(0, 5);
            end else begin
                seg_left    <= seg_left - 1;
                i_out_stall <= stall_phase;
            end
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: found %0d start %0d count %0d",
                         $time, o_found, o_start_page, o_page_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0d, got %0d",
                             $time, want.found, o_found);
                    error_count++;
                end
                if (o_start_page !== want.start_page) begin
                    $display("%0t: start_page mismatch, expected %0d, got %0d",
                             $time, want.start_page, o_start_page);
                    error_count++;
                end
                if (o_page_count !== want.page_count) begin
                    $display("%0t: page_count mismatch, expected %0d, got %0d",
                             $time, want.page_count, o_page_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("** page_bitmap_first_fit_allocator_top: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_actions();
        test_setting_extremes();
        test_receiver_hold();
        test_random_settings();
        repeat (END_DRAIN) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** page_bitmap_first_fit_allocator_top: PASSED **");
        end else begin
            $display("** page_bitmap_first_fit_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
